### hdl/ssdr_pkg.sv
package ssdr_pkg;

  localparam int NumSets    = 2048;
  localparam int NumWays    = 16;
  localparam int SigBits    = 6;
  localparam int LeaderSets = 32;
  localparam int SetW       = $clog2(NumSets);
  localparam int WayW       = $clog2(NumWays);
  localparam int SigCount   = 1 << SigBits;
  localparam int RowW       = 2 * NumWays;
  localparam int SigRowW    = SigBits * NumWays;

  localparam logic [1:0] RrpvMax = 2'd3;
  localparam logic [9:0] PselMax = 10'd1023;
  localparam logic [9:0] PselRst = 10'd512;
  localparam logic [1:0] StrRst  = 2'd2;

  localparam logic       CfgStream = 1'b0;
  localparam logic       CfgPsel   = 1'b1;

  localparam logic       ActFind   = 1'b0;
  localparam logic       ActUpdate = 1'b1;

  localparam int QDepth = 2;
  localparam int QCntW  = $clog2(QDepth) + 1;

  typedef struct packed {
    logic        action;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [15:0] addr_low;
    logic [5:0]  pc_signature;
    logic        was_hit;
    logic [4:0]  bip_draw;
  } in_word_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       streaming_seen;
    logic [1:0] inserted_rrpv;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    logic               action;
    logic [SetW-1:0]    set;
    logic [WayW-1:0]    way;
    logic [SigBits-1:0] sig;
    logic               was_hit;
    logic               streaming;
    logic               lip_leader;
    logic               bip_leader;
    logic               draw_zero;
  } cmd_t;

endpackage

### hdl/ssdr_front.sv
module ssdr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ssdr_pkg::in_word_t in_word_i,
  input  logic [1:0]        stream_thr_i,
  output logic              push_o,
  output ssdr_pkg::cmd_t    cmd_o,
  input  logic              q_full_i
);

  typedef enum logic [1:0] {SIdle, SRead, SPush, SClear} state_e;

  state_e state_q;
  ssdr_pkg::in_word_t w_q;
  ssdr_pkg::cmd_t cmd_q;
  logic [ssdr_pkg::SetW-1:0] clr_q;

  logic [15:0] addr_mem [ssdr_pkg::NumSets];
  logic [15:0] dlt_mem [ssdr_pkg::NumSets];
  logic [1:0]  conf_mem [ssdr_pkg::NumSets];
  logic [15:0] addr_rd_q, dlt_rd_q;
  logic [1:0]  conf_rd_q;

  logic [ssdr_pkg::SetW-1:0] set_s;
  logic [15:0] last_a, last_d, delta;
  logic [1:0] conf_o, conf_n;
  logic mono;

  assign set_s  = w_q.set_index[ssdr_pkg::SetW-1:0];
  assign last_a = addr_rd_q;
  assign last_d = dlt_rd_q;
  assign conf_o = conf_rd_q;
  assign delta  = w_q.addr_low - last_a;
  assign mono   = (delta == last_d) && (delta != 16'd0);
  always_comb begin
    conf_n = conf_o;
    if (mono) begin
      if (conf_o != 2'd3) conf_n = conf_o + 2'd1;
    end else if (conf_o != 2'd0) begin
      conf_n = conf_o - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_rd_q <= addr_mem[in_word_i.set_index[ssdr_pkg::SetW-1:0]];
    dlt_rd_q  <= dlt_mem[in_word_i.set_index[ssdr_pkg::SetW-1:0]];
    conf_rd_q <= conf_mem[in_word_i.set_index[ssdr_pkg::SetW-1:0]];
    if (state_q == SClear) begin
      addr_mem[clr_q] <= '0;
      dlt_mem[clr_q]  <= '0;
      conf_mem[clr_q] <= '0;
    end else if (state_q == SRead && w_q.action == ssdr_pkg::ActUpdate) begin
      addr_mem[set_s] <= w_q.addr_low;
      dlt_mem[set_s]  <= delta;
      conf_mem[set_s] <= conf_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      w_q     <= '0;
      cmd_q   <= '0;
    end else begin
      unique case (state_q)
        SClear: begin
          clr_q <= clr_q + ssdr_pkg::SetW'(1);
          if (clr_q == '1) state_q <= SIdle;
        end
        SIdle: if (start) begin
          w_q <= in_word_i;
          state_q <= SRead;
        end
        SRead: begin
          cmd_q.action     <= w_q.action;
          cmd_q.set        <= set_s;
          cmd_q.way        <= w_q.way_index[ssdr_pkg::WayW-1:0];
          cmd_q.sig        <= w_q.pc_signature[ssdr_pkg::SigBits-1:0];
          cmd_q.was_hit    <= w_q.was_hit;
          cmd_q.streaming  <= conf_n >= stream_thr_i;
          cmd_q.lip_leader <= 32'(set_s) < ssdr_pkg::LeaderSets;
          cmd_q.bip_leader <= 32'(set_s) >= ssdr_pkg::LeaderSets &&
                              32'(set_s) >= ssdr_pkg::NumSets - ssdr_pkg::LeaderSets;
          cmd_q.draw_zero  <= w_q.bip_draw == 5'd0;
          state_q <= SPush;
        end
        SPush: if (!q_full_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy   = state_q != SIdle;
  assign push_o = state_q == SPush && !q_full_i;
  assign cmd_o  = cmd_q;

endmodule

### hdl/ssdr_queue.sv
module ssdr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssdr_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ssdr_pkg::cmd_t cmd_o
);

  ssdr_pkg::cmd_t mem_q [ssdr_pkg::QDepth];
  logic [ssdr_pkg::QCntW-1:0] cnt_q;
  logic [$clog2(ssdr_pkg::QDepth)-1:0] wp_q, rp_q;

  assign full_o  = 32'(cnt_q) == ssdr_pkg::QDepth;
  assign empty_o = cnt_q == '0;
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= '0;
      rp_q  <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + ssdr_pkg::QCntW'(push_i) - ssdr_pkg::QCntW'(pop_i);
    end
  end

endmodule

### hdl/ssdr_back.sv
module ssdr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  ssdr_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  input  logic [9:0]          psel_thr_i,
  output logic                idle_o,
  output logic                done_o,
  output ssdr_pkg::out_word_t result_o
);

  typedef enum logic [1:0] {SIdle, SRead, SExec, SClear} state_e;

  state_e state_q;
  ssdr_pkg::cmd_t c_q;
  logic [ssdr_pkg::SetW-1:0] clr_q;

  logic [ssdr_pkg::RowW-1:0] rrpv_mem [ssdr_pkg::NumSets];
  logic [ssdr_pkg::SigRowW-1:0] sig_mem [ssdr_pkg::NumSets];
  logic [1:0] ctr_mem [ssdr_pkg::SigCount];
  logic [ssdr_pkg::RowW-1:0] row_rd_q, row, row_n;
  logic [ssdr_pkg::SigRowW-1:0] sig_rd_q, sig_row_n;
  logic [ssdr_pkg::SigBits-1:0] old_sig, ctr_addr;
  logic [1:0] ctr_rd_q;
  logic [9:0] psel_q;
  logic [1:0] top, add, ins, cnt;
  logic [ssdr_pkg::WayW-1:0] vic;
  logic use_lip;
  ssdr_pkg::out_word_t res_d;

  assign row      = row_rd_q;
  assign old_sig  = sig_rd_q[ssdr_pkg::SigBits*c_q.way +: ssdr_pkg::SigBits];
  assign ctr_addr = c_q.was_hit ? old_sig : c_q.sig;
  assign cnt      = ctr_rd_q;

  always_comb begin
    sig_row_n = sig_rd_q;
    sig_row_n[ssdr_pkg::SigBits*c_q.way +: ssdr_pkg::SigBits] = c_q.sig;
  end

  always_comb begin
    top = 2'd0;
    for (int w = 0; w < ssdr_pkg::NumWays; w++)
      if (row[2*w +: 2] > top) top = row[2*w +: 2];
    add = ssdr_pkg::RrpvMax - top;
    row_n = row;
    vic = '0;
    for (int w = ssdr_pkg::NumWays - 1; w >= 0; w--) begin
      row_n[2*w +: 2] = row[2*w +: 2] + add;
      if (row_n[2*w +: 2] == ssdr_pkg::RrpvMax) vic = ssdr_pkg::WayW'(w);
    end
    priority if (c_q.lip_leader) use_lip = 1'b1;
    else if (c_q.bip_leader) use_lip = 1'b0;
    else use_lip = psel_q >= psel_thr_i;
    priority if (c_q.streaming || cnt == 2'd0) ins = ssdr_pkg::RrpvMax;
    else if (cnt >= 2'd2) ins = 2'd0;
    else if (use_lip) ins = ssdr_pkg::RrpvMax;
    else ins = c_q.draw_zero ? 2'd0 : ssdr_pkg::RrpvMax;
    if (c_q.action == ssdr_pkg::ActUpdate) begin
      row_n = row;
      row_n[2*c_q.way +: 2] = c_q.was_hit ? 2'd0 : ins;
    end
    res_d = '0;
    if (c_q.action == ssdr_pkg::ActFind) begin
      res_d.victim_way = 4'(vic);
    end else begin
      res_d.streaming_seen = c_q.streaming;
      res_d.inserted_rrpv  = c_q.was_hit ? 2'd0 : ins;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      row_rd_q <= rrpv_mem[cmd_i.set];
      sig_rd_q <= sig_mem[cmd_i.set];
    end
    if (state_q == SRead) ctr_rd_q <= ctr_mem[ctr_addr];
    if (state_q == SClear) begin
      rrpv_mem[clr_q] <= '1;
      sig_mem[clr_q]  <= '0;
      ctr_mem[clr_q[ssdr_pkg::SigBits-1:0]] <= 2'd1;
    end else if (state_q == SExec) begin
      rrpv_mem[c_q.set] <= row_n;
      if (c_q.action == ssdr_pkg::ActUpdate && !c_q.was_hit) sig_mem[c_q.set] <= sig_row_n;
      if (c_q.action == ssdr_pkg::ActUpdate && c_q.was_hit && ctr_rd_q != 2'd3)
        ctr_mem[old_sig] <= ctr_rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      clr_q    <= '0;
      c_q      <= '0;
      psel_q   <= ssdr_pkg::PselRst;
      done_o   <= 1'b0;
      result_o <= '0;
    end else begin
      done_o <= state_q == SExec;
      unique case (state_q)
        SClear: begin
          clr_q <= clr_q + ssdr_pkg::SetW'(1);
          if (clr_q == '1) state_q <= SIdle;
        end
        SIdle: if (!empty_i) begin
          c_q <= cmd_i;
          state_q <= SRead;
        end
        SRead: state_q <= SExec;
        SExec: begin
          result_o <= res_d;
          if (c_q.action == ssdr_pkg::ActUpdate && c_q.was_hit) begin
            if (c_q.lip_leader) begin
              if (psel_q != ssdr_pkg::PselMax) psel_q <= psel_q + 10'd1;
            end else if (c_q.bip_leader) begin
              if (psel_q != 10'd0) psel_q <= psel_q - 10'd1;
            end
          end
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign pop_o  = state_q == SIdle && !empty_i;
  assign idle_o = state_q == SIdle && empty_i;

endmodule

### hdl/ship_stream_dip_replacement.sv
// The front classifies each word and pushes a command into the queue; the back pops
//   it, reads its tables, executes and registers result_o together with done_o.
// The front can take a new word while the back still works on older ones.
// Reset: asynchronous, active low, then a clearing pass of the metadata memories
//   with busy high. The receiver cannot stall done_o.
module ship_stream_dip_replacement (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ssdr_pkg::in_word_t  in_word_i,
  output logic                done_o,
  output ssdr_pkg::out_word_t result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [9:0]          cfg_data_i
);

  logic [1:0] str_thr_q;
  logic [9:0] psel_thr_q;
  logic push, full, pop, empty, back_idle;
  ssdr_pkg::cmd_t fcmd, qcmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_thr_q  <= ssdr_pkg::StrRst;
      psel_thr_q <= ssdr_pkg::PselRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssdr_pkg::CfgStream: str_thr_q <= cfg_data_i[1:0];
        ssdr_pkg::CfgPsel:   psel_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ssdr_front u_front (
    .clk_i, .rst_ni, .start, .busy, .in_word_i,
    .stream_thr_i(str_thr_q), .push_o(push), .cmd_o(fcmd), .q_full_i(full)
  );

  ssdr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(fcmd), .full_o(full),
    .pop_i(pop), .empty_o(empty), .cmd_o(qcmd)
  );

  ssdr_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(qcmd), .pop_o(pop),
    .psel_thr_i(psel_thr_q), .idle_o(back_idle), .done_o, .result_o
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("push into full queue");
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(!back_idle)) else $error("result without work");

endmodule

### tb/ship_stream_dip_replacement_test.sv
module ship_stream_dip_replacement_test;

  localparam int WatchLimit = 10000;
  localparam int DrainWait  = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  ssdr_pkg::in_word_t  in_word_i;
  logic                done_o;
  ssdr_pkg::out_word_t result_o;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [9:0]          cfg_data_i;

  ship_stream_dip_replacement dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_word_i(in_word_i), .done_o(done_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // predicted metadata of the replacement engine
  logic [1:0]  rrpv_m [ssdr_pkg::NumSets*ssdr_pkg::NumWays];
  logic [5:0]  sig_m [ssdr_pkg::NumSets*ssdr_pkg::NumWays];
  logic [1:0]  reuse_ctr [ssdr_pkg::SigCount];
  logic [1:0]  conf_m [ssdr_pkg::NumSets];
  logic [15:0] prev_addr [ssdr_pkg::NumSets];
  logic [15:0] prev_delta [ssdr_pkg::NumSets];
  logic [9:0]  psel;
  logic [1:0]  stream_thr;
  logic [9:0]  psel_thr;

  ssdr_pkg::out_word_t expected_q [$];
  int        errors;
  int        idle_cycles;
  int        accepted;

  typedef struct {
    ssdr_pkg::in_word_t  w;
    logic                has_exp;
    ssdr_pkg::out_word_t exp;
  } row_t;
  row_t rows [$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic ssdr_pkg::out_word_t predict_access(ssdr_pkg::in_word_t w);
    ssdr_pkg::out_word_t r;
    int          base;
    int          s;
    int          wy;
    logic [1:0]  top;
    logic [15:0] delta;
    logic        strm;
    logic        lipl;
    logic        bipl;
    logic        use_lip;
    logic [1:0]  ins;
    logic [5:0]  old;
    s = w.set_index;
    wy = w.way_index;
    base = s * ssdr_pkg::NumWays;
    r = '0;
    lipl = s < ssdr_pkg::LeaderSets;
    bipl = !lipl && (s + ssdr_pkg::LeaderSets >= ssdr_pkg::NumSets);
    if (w.action == ssdr_pkg::ActFind) begin
      top = 2'd0;
      for (int i = 0; i < ssdr_pkg::NumWays; i++)
        if (rrpv_m[base+i] > top) top = rrpv_m[base+i];
      for (int i = 0; i < ssdr_pkg::NumWays; i++)
        rrpv_m[base+i] = rrpv_m[base+i] + (ssdr_pkg::RrpvMax - top);
      for (int i = ssdr_pkg::NumWays - 1; i >= 0; i--)
        if (rrpv_m[base+i] == ssdr_pkg::RrpvMax) r.victim_way = 4'(i);
      return r;
    end
    delta = w.addr_low - prev_addr[s];
    if (delta == prev_delta[s] && delta != 16'd0) begin
      if (conf_m[s] < 2'd3) conf_m[s]++;
    end else if (conf_m[s] > 2'd0) begin
      conf_m[s]--;
    end
    prev_delta[s] = delta;
    prev_addr[s] = w.addr_low;
    strm = conf_m[s] >= stream_thr;
    r.streaming_seen = strm;
    if (w.was_hit) begin
      old = sig_m[base+wy];
      if (reuse_ctr[old] < 2'd3) reuse_ctr[old]++;
      rrpv_m[base+wy] = 2'd0;
      if (lipl) begin
        if (psel < ssdr_pkg::PselMax) psel++;
      end else if (bipl) begin
        if (psel > 10'd0) psel--;
      end
      return r;
    end
    use_lip = lipl ? 1'b1 : bipl ? 1'b0 : (psel >= psel_thr);
    if (strm) ins = ssdr_pkg::RrpvMax;
    else if (reuse_ctr[w.pc_signature] >= 2'd2) ins = 2'd0;
    else if (reuse_ctr[w.pc_signature] == 2'd1)
      ins = use_lip ? ssdr_pkg::RrpvMax : (w.bip_draw == 5'd0 ? 2'd0 : ssdr_pkg::RrpvMax);
    else ins = ssdr_pkg::RrpvMax;
    rrpv_m[base+wy] = ins;
    sig_m[base+wy] = w.pc_signature;
    r.inserted_rrpv = ins;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) accepted++;
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word %p", $time, result_o);
          errors++;
        end else begin
          ssdr_pkg::out_word_t e;
          e = expected_q.pop_front();
          if (e.victim_way !== result_o.victim_way)
            $display("%0t: victim_way exp %0d got %0d", $time, e.victim_way,
                     result_o.victim_way);
          if (e.streaming_seen !== result_o.streaming_seen)
            $display("%0t: streaming_seen exp %0d got %0d", $time, e.streaming_seen,
                     result_o.streaming_seen);
          if (e.inserted_rrpv !== result_o.inserted_rrpv)
            $display("%0t: inserted_rrpv exp %0d got %0d", $time, e.inserted_rrpv,
                     result_o.inserted_rrpv);
          if (e !== result_o) errors++;
        end
      end
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("ship_stream_dip_replacement_test failed");
        $finish;
      end
    end
  end

  task automatic send_word(ssdr_pkg::in_word_t w, logic has_exp, ssdr_pkg::out_word_t exp);
    ssdr_pkg::out_word_t p;
    in_word_i <= w;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = predict_access(w);
    if (has_exp && p !== exp) begin
      $display("%0t: table row exp %p predicted %p", $time, exp, p);
      errors++;
    end
    expected_q.push_back(p);
  endtask

  task automatic pause_sender();
    if ($urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 10'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ssdr_pkg::CfgStream) stream_thr = 2'(val);
    else psel_thr = 10'(val);
  endtask

  function automatic ssdr_pkg::in_word_t mk(logic a, int s, int wy, int ad, int sg, logic h,
                                            int d);
    ssdr_pkg::in_word_t w;
    w.action = a; w.set_index = 11'(s); w.way_index = 4'(wy); w.addr_low = 16'(ad);
    w.pc_signature = 6'(sg); w.was_hit = h; w.bip_draw = 5'(d);
    return w;
  endfunction

  function automatic ssdr_pkg::in_word_t rand_word(int hot_set, int stride, int step);
    ssdr_pkg::in_word_t w;
    w = mk($urandom_range(0, 3) == 0 ? ssdr_pkg::ActFind : ssdr_pkg::ActUpdate, 0,
           $urandom_range(0, 15), $urandom_range(0, 65535), $urandom_range(0, 63),
           1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 31));
    if ($urandom_range(0, 3) != 0) begin
      w.set_index = 11'(hot_set);
      w.addr_low = 16'(stride * step);
      w.pc_signature = 6'($urandom_range(0, 7));
    end else begin
      w.set_index = 11'($urandom_range(0, 2047));
    end
    return w;
  endfunction

  initial begin
    int hot;
    int stride;
    ssdr_pkg::out_word_t x;
    errors = 0; accepted = 0; idle_cycles = 0;
    start = 1'b0; in_word_i = '0; cfg_we_i = 1'b0; cfg_idx_i = ssdr_pkg::CfgStream;
    cfg_data_i = '0;
    for (int i = 0; i < ssdr_pkg::NumSets*ssdr_pkg::NumWays; i++) begin
      rrpv_m[i] = ssdr_pkg::RrpvMax; sig_m[i] = '0;
    end
    for (int i = 0; i < ssdr_pkg::SigCount; i++) reuse_ctr[i] = 2'd1;
    for (int i = 0; i < ssdr_pkg::NumSets; i++) begin
      conf_m[i] = '0; prev_addr[i] = '0; prev_delta[i] = '0;
    end
    psel = ssdr_pkg::PselRst; stream_thr = ssdr_pkg::StrRst; psel_thr = ssdr_pkg::PselRst;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    x = '0;
    rows.push_back('{mk(ssdr_pkg::ActFind, 0, 0, 0, 0, 1'b0, 0), 1'b1, x});
    rows.push_back('{mk(ssdr_pkg::ActFind, 2047, 15, 65535, 63, 1'b1, 31), 1'b1, x});
    x.inserted_rrpv = 2'd3;
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 5, 0, 0, 0, 1'b0, 0), 1'b1, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 40, 15, 16, 63, 1'b0, 31), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 2040, 3, 32, 9, 1'b0, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 2040, 3, 64, 9, 1'b1, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 2, 1, 100, 9, 1'b1, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 2, 1, 200, 9, 1'b0, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 2, 1, 300, 9, 1'b0, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 2, 2, 400, 9, 1'b0, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActFind, 2, 0, 0, 0, 1'b0, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 700, 7, 65535, 20, 1'b0, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 700, 7, 65535, 20, 1'b1, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActFind, 700, 0, 0, 0, 1'b0, 0), 1'b0, x});
    rows.push_back('{mk(ssdr_pkg::ActUpdate, 1000, 4, 7, 33, 1'b0, 1), 1'b0, x});
    foreach (rows[i]) send_word(rows[i].w, rows[i].has_exp, rows[i].exp);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(ssdr_pkg::CfgStream, 0); write_reg(ssdr_pkg::CfgPsel, 0); end
        1: begin write_reg(ssdr_pkg::CfgStream, 3); write_reg(ssdr_pkg::CfgPsel, 1023); end
        2: begin
          write_reg(ssdr_pkg::CfgStream, 1);
          write_reg(ssdr_pkg::CfgPsel, $urandom_range(0, 1023));
        end
        3: begin write_reg(ssdr_pkg::CfgStream, 2); write_reg(ssdr_pkg::CfgPsel, 512); end
        default: begin
          write_reg(ssdr_pkg::CfgStream, $urandom_range(0, 3));
          write_reg(ssdr_pkg::CfgPsel, $urandom_range(400, 624));
        end
      endcase
      hot = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(1984, 2047);
      stride = $urandom_range(1, 65535);
      for (int k = 0; k < 340; k++) begin
        if (k % 40 == 0) begin
          hot = $urandom_range(0, 2) == 0 ? $urandom_range(600, 700) : hot ^ 1;
          stride = $urandom_range(1, 65535);
        end
        send_word(rand_word(hot, stride, k), 1'b0, x);
        if (k > 100) pause_sender();
      end
      settle();
    end

    if (errors == 0) $display("ship_stream_dip_replacement_test passed");
    else $display("ship_stream_dip_replacement_test failed");
    $finish;
  end

endmodule
